@@ src/scc_pkg.sv @@
// Shared types and constants for the sector cache clock replacement engine.
package scc_pkg;

  localparam int CMD_W    = 2;
  localparam int SECTOR_W = 32;
  localparam int SLOT_W   = 6;

  typedef enum logic [CMD_W-1:0] {
    CMD_READ  = 2'd0,
    CMD_WRITE = 2'd1,
    CMD_SYNC  = 2'd2,
    CMD_NONE  = 2'd3
  } cmd_e;

  typedef struct packed {
    logic [CMD_W-1:0]    command;
    logic [SECTOR_W-1:0] sector;
  } in_item_t;

  typedef struct packed {
    logic [SLOT_W-1:0]   slot;
    logic                hit;
    logic                fill_needed;
    logic                writeback_needed;
    logic [SECTOR_W-1:0] writeback_sector;
    logic                last;
  } out_item_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_LOOKUP,
    ST_SWEEP,
    ST_SYNC,
    ST_FLUSH
  } state_e;

  typedef enum logic [1:0] {
    IDX_HOLD,
    IDX_ZERO,
    IDX_NEXT,
    IDX_HAND
  } idx_op_e;

  typedef enum logic [2:0] {
    WR_NONE,
    WR_CLEAR,
    WR_HIT,
    WR_UNUSE,
    WR_FILL,
    WR_CLEAN
  } wr_op_e;

  typedef enum logic [2:0] {
    EM_NONE,
    EM_HIT,
    EM_FILL,
    EM_PEND,
    EM_PEND_LAST
  } emit_op_e;

  typedef struct packed {
    idx_op_e  idx_op;
    logic     rd_en;
    wr_op_e   wr_op;
    emit_op_e emit_op;
    logic     pend_load;
    logic     pend_clr;
    logic     req_load;
    logic     hand_adv;
  } ctrl_cmd_t;

  typedef struct packed {
    logic match;
    logic used;
    logic dirty_vld;
    logic idx_last;
    logic out_free;
    logic pend_vld;
  } ctrl_sts_t;

endpackage

@@ src/scc_datapath.sv @@
// Slot table memory, scan index, clock hand, sync holding register and output register.
module scc_datapath #(
  parameter int ENTRIES     = 64,
  parameter int SECTOR_BITS = 32
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  scc_pkg::ctrl_cmd_t cmd_i,
  output scc_pkg::ctrl_sts_t sts_o,
  input  scc_pkg::in_item_t  in_data_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output scc_pkg::out_item_t out_data_o
);
  import scc_pkg::*;

  localparam int IdxW = $clog2(ENTRIES);
  localparam int TagW = (SECTOR_BITS < SECTOR_W) ? SECTOR_BITS : SECTOR_W;
  localparam logic [IdxW-1:0] IdxLast = IdxW'(ENTRIES - 1);

  typedef struct packed {
    logic [TagW-1:0] tag;
    logic            vld;
    logic            used;
    logic            dirty;
  } entry_t;

  entry_t          mem_q [ENTRIES];
  entry_t          rdata_q;
  entry_t          wdata;
  logic            wr_en;
  logic [IdxW-1:0] idx_q, idx_d, idx_inc;
  logic [IdxW-1:0] hand_q, hand_d;
  logic            req_write_q;
  logic [TagW-1:0] req_tag_q;
  logic            pend_vld_q, pend_vld_d;
  logic [IdxW-1:0] pend_idx_q;
  logic [TagW-1:0] pend_tag_q;
  logic            out_valid_q, out_valid_d;
  out_item_t       out_q, out_d;
  logic            out_free;
  logic            evict;

  assign idx_inc  = (idx_q == IdxLast) ? '0 : idx_q + 1'b1;
  assign out_free = !out_valid_q || !out_stall_i;
  assign evict    = rdata_q.vld & rdata_q.dirty;
  assign wr_en    = (cmd_i.wr_op != WR_NONE);

  always_comb begin
    unique case (cmd_i.idx_op)
      IDX_HOLD: idx_d = idx_q;
      IDX_ZERO: idx_d = '0;
      IDX_NEXT: idx_d = idx_inc;
      IDX_HAND: idx_d = hand_q;
      default:  idx_d = idx_q;
    endcase
  end

  assign hand_d = cmd_i.hand_adv ? idx_inc : hand_q;

  always_comb begin
    wdata = rdata_q;
    unique case (cmd_i.wr_op)
      WR_NONE:  wdata = rdata_q;
      WR_CLEAR: wdata = '0;
      WR_HIT: begin
        wdata.used  = 1'b1;
        wdata.dirty = rdata_q.dirty | req_write_q;
      end
      WR_UNUSE: wdata.used = 1'b0;
      WR_FILL: begin
        wdata.tag   = req_tag_q;
        wdata.vld   = 1'b1;
        wdata.used  = 1'b1;
        wdata.dirty = req_write_q;
      end
      WR_CLEAN: wdata.dirty = 1'b0;
      default:  wdata = rdata_q;
    endcase
  end

  always_comb begin
    out_d       = '0;
    out_valid_d = out_valid_q && out_stall_i;
    unique case (cmd_i.emit_op)
      EM_NONE: out_d = out_q;
      EM_HIT: begin
        out_d.slot  = SLOT_W'(idx_q);
        out_d.hit   = 1'b1;
        out_d.last  = 1'b1;
        out_valid_d = 1'b1;
      end
      EM_FILL: begin
        out_d.slot             = SLOT_W'(idx_q);
        out_d.fill_needed      = 1'b1;
        out_d.writeback_needed = evict;
        out_d.writeback_sector = evict ? SECTOR_W'(rdata_q.tag) : '0;
        out_d.last             = 1'b1;
        out_valid_d            = 1'b1;
      end
      EM_PEND, EM_PEND_LAST: begin
        out_d.slot             = SLOT_W'(pend_idx_q);
        out_d.writeback_needed = 1'b1;
        out_d.writeback_sector = SECTOR_W'(pend_tag_q);
        out_d.last             = (cmd_i.emit_op == EM_PEND_LAST);
        out_valid_d            = 1'b1;
      end
      default: out_d = out_q;
    endcase
  end

  always_comb begin
    pend_vld_d = pend_vld_q;
    if (cmd_i.pend_clr) begin
      pend_vld_d = 1'b0;
    end
    if (cmd_i.pend_load) begin
      pend_vld_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[idx_q] <= wdata;
    end
    if (cmd_i.rd_en) begin
      rdata_q <= mem_q[idx_d];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q       <= '0;
      hand_q      <= '0;
      pend_vld_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      idx_q       <= idx_d;
      hand_q      <= hand_d;
      pend_vld_q  <= pend_vld_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.req_load) begin
      req_write_q <= (in_data_i.command == CMD_WRITE);
      req_tag_q   <= in_data_i.sector[TagW-1:0];
    end
    if (cmd_i.pend_load) begin
      pend_idx_q <= idx_q;
      pend_tag_q <= rdata_q.tag;
    end
    out_q <= out_d;
  end

  always_comb begin
    sts_o           = '0;
    sts_o.match     = rdata_q.vld && (rdata_q.tag == req_tag_q);
    sts_o.used      = rdata_q.used;
    sts_o.dirty_vld = evict;
    sts_o.idx_last  = (idx_q == IdxLast);
    sts_o.out_free  = out_free;
    sts_o.pend_vld  = pend_vld_q;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  a_emit_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.emit_op != EM_NONE |-> out_free)
    else $error("result loaded while output register busy");

  a_port_conflict: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr_en && cmd_i.rd_en |-> idx_d != idx_q)
    else $error("read and write of the same slot in one cycle");

endmodule

@@ src/scc_ctrl.sv @@
// Controller state machine for lookup, clock sweep, sync scan and reset clearing.
module scc_ctrl (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  input  logic [scc_pkg::CMD_W-1:0] in_cmd_i,
  output logic                      in_stall_o,
  input  scc_pkg::ctrl_sts_t        sts_i,
  output scc_pkg::ctrl_cmd_t        cmd_o
);
  import scc_pkg::*;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d      = state_q;
    cmd_o        = '0;
    cmd_o.idx_op = IDX_HOLD;
    cmd_o.wr_op  = WR_NONE;
    cmd_o.emit_op = EM_NONE;
    in_stall_o   = (state_q != ST_IDLE);
    unique case (state_q)
      ST_CLEAR: begin
        cmd_o.wr_op  = WR_CLEAR;
        cmd_o.idx_op = IDX_NEXT;
        if (sts_i.idx_last) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.req_load = 1'b1;
          unique case (cmd_e'(in_cmd_i))
            CMD_READ, CMD_WRITE: begin
              cmd_o.idx_op = IDX_ZERO;
              cmd_o.rd_en  = 1'b1;
              state_d      = ST_LOOKUP;
            end
            CMD_SYNC: begin
              cmd_o.idx_op   = IDX_ZERO;
              cmd_o.rd_en    = 1'b1;
              cmd_o.pend_clr = 1'b1;
              state_d        = ST_SYNC;
            end
            CMD_NONE: state_d = ST_IDLE;
            default:  state_d = ST_IDLE;
          endcase
        end
      end
      ST_LOOKUP: begin
        if (sts_i.match) begin
          if (sts_i.out_free) begin
            cmd_o.wr_op   = WR_HIT;
            cmd_o.emit_op = EM_HIT;
            state_d       = ST_IDLE;
          end
        end else if (sts_i.idx_last) begin
          cmd_o.idx_op = IDX_HAND;
          cmd_o.rd_en  = 1'b1;
          state_d      = ST_SWEEP;
        end else begin
          cmd_o.idx_op = IDX_NEXT;
          cmd_o.rd_en  = 1'b1;
        end
      end
      ST_SWEEP: begin
        if (sts_i.used) begin
          cmd_o.wr_op  = WR_UNUSE;
          cmd_o.idx_op = IDX_NEXT;
          cmd_o.rd_en  = 1'b1;
        end else if (sts_i.out_free) begin
          cmd_o.wr_op    = WR_FILL;
          cmd_o.emit_op  = EM_FILL;
          cmd_o.hand_adv = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      ST_SYNC: begin
        if (!(sts_i.dirty_vld && sts_i.pend_vld && !sts_i.out_free)) begin
          if (sts_i.dirty_vld) begin
            cmd_o.wr_op     = WR_CLEAN;
            cmd_o.pend_load = 1'b1;
            if (sts_i.pend_vld) begin
              cmd_o.emit_op = EM_PEND;
            end
          end
          if (sts_i.idx_last) begin
            state_d = ST_FLUSH;
          end else begin
            cmd_o.idx_op = IDX_NEXT;
            cmd_o.rd_en  = 1'b1;
          end
        end
      end
      ST_FLUSH: begin
        if (!sts_i.pend_vld) begin
          state_d = ST_IDLE;
        end else if (sts_i.out_free) begin
          cmd_o.emit_op  = EM_PEND_LAST;
          cmd_o.pend_clr = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: state_d = ST_CLEAR;
    endcase
  end

  a_miss_sweeps: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_LOOKUP && !sts_i.match && sts_i.idx_last) |=> state_q == ST_SWEEP)
    else $error("full lookup miss did not start the clock sweep");

  a_sync_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_IDLE && in_valid_i && in_cmd_i == CMD_SYNC)
      |=> (state_q == ST_SYNC && !sts_i.pend_vld))
    else $error("sync did not start with an empty holding register");

  a_flush_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_FLUSH ##1 state_q == ST_IDLE) |-> !sts_i.pend_vld)
    else $error("sync ended with a writeback still held");

endmodule

@@ src/sector_cache_clock_replacement.sv @@
// Top level of the sector cache tag and clock replacement engine.
// After reset the block clears every slot of the slot table in turn and holds
// in_stall_o high meanwhile. The slot table is a single memory with one write and
// one read per cycle, so every command walks it one slot per cycle while no result
// waits for a busy output register: an access that hits in slot k ends its scan at
// slot k; a miss scans all ENTRIES slots and then sweeps from the clock hand, clearing
// used bits, until it finds a slot whose used bit is clear; a sync scans every slot.
// A result waits while it cannot enter the output register. Only one command is in
// progress at a time; an output register holds the last result so the next
// transaction can be accepted while it waits.
module sector_cache_clock_replacement #(
  parameter int ENTRIES     = 64,
  parameter int SECTOR_BITS = 32
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  scc_pkg::in_item_t  in_data_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output scc_pkg::out_item_t out_data_o
);
  import scc_pkg::*;

  ctrl_cmd_t cmd;
  ctrl_sts_t sts;

  scc_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_cmd_i   (in_data_i.command),
    .in_stall_o (in_stall_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  scc_datapath #(
    .ENTRIES     (ENTRIES),
    .SECTOR_BITS (SECTOR_BITS)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

endmodule
